@@ hw/rtl/dcf_pkg.sv @@
// Shared types, constants and helper functions for the debug character FIFO.
package dcf_pkg;

	// Ring size; one slot always stays empty.
	localparam int unsigned FIFO_DEPTH = 256;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	// Counts are reported in eight bits, so widen first when the pointer is narrower.
	localparam int unsigned CNT_W      = (PTR_W > 8) ? PTR_W : 8;

	localparam int unsigned FUNC_W     = 3;
	localparam int unsigned VALUE_W    = 16;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned LEN_W      = 3;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned NUM_DIGITS = 5;

	localparam int unsigned S_TDATA_W  = 24;
	localparam int unsigned M_TDATA_W  = 32;

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_X      = 8'h78;
	// Adding this to a nibble of ten or more gives the uppercase letter.
	localparam logic [CHAR_W-1:0] CHAR_HEX_AF = 8'h37;

	// Reciprocal of ten scaled by 2^19; exact for every 16-bit value.
	localparam logic [VALUE_W-1:0] RECIP_TEN   = 16'd52429;
	localparam int unsigned        RECIP_SHIFT = 19;

	localparam logic [LEN_W-1:0] NEED_CHAR  = 3'd1;
	localparam logic [LEN_W-1:0] NEED_DEC   = 3'd5;
	localparam logic [LEN_W-1:0] NEED_HEX16 = 3'd6;
	localparam logic [LEN_W-1:0] NEED_HEX8  = 3'd4;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CHAR  = 3'd0,
		FUNC_DEC   = 3'd1,
		FUNC_HEX16 = 3'd2,
		FUNC_HEX8  = 3'd3,
		FUNC_READ  = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CONV,
		ST_WRITE,
		ST_READ,
		ST_RDWAIT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic conv_step;
		logic write_step;
		logic read_issue;
		logic read_capture;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic go_conv;
		logic go_write;
		logic go_read;
		logic conv_last;
		logic write_last;
		logic out_free;
	} stat_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] nib);
		logic [CHAR_W-1:0] ext;
		ext = {{(CHAR_W-DIGIT_W){1'b0}}, nib};
		return (nib < 4'd10) ? (CHAR_ZERO + ext) : (CHAR_HEX_AF + ext);
	endfunction

	function automatic logic [LEN_W-1:0] dec_len(input logic [VALUE_W-1:0] v);
		logic [LEN_W-1:0] n;
		if (v >= 16'd10000) begin
			n = 3'd5;
		end else if (v >= 16'd1000) begin
			n = 3'd4;
		end else if (v >= 16'd100) begin
			n = 3'd3;
		end else if (v >= 16'd10) begin
			n = 3'd2;
		end else begin
			n = 3'd1;
		end
		return n;
	endfunction

endpackage

@@ hw/rtl/debug_char_fifo_with_number_format.sv @@
// Top level of the debug character FIFO with decimal and hex number formatting.
//
//  Channel   Direction  Signals                    Carries
//  s_*       in         s_tvalid s_tready s_tdata  one command: read or one kind of append
//  m_*       out        m_tvalid m_tready m_tdata  one result per command
//
// Each accepted transaction runs decode, then its own steps, then the result:
// a raw character, hex8 or hex16 append writes its characters to the store, a read
//   issues the store read and captures the character, a decimal append runs five
//   conversion steps and then one store write per digit, and a refused or unused
//   command goes straight to the result. The single character store write port
//   sets the pace: one character a cycle.
// Reset is asynchronous and active low; both ring pointers clear, so the ring starts empty.
// A new command is taken while a result still waits on m_*; the block then holds its
// next result until m_tready takes the earlier one.
module debug_char_fifo_with_number_format (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata from bit 0: func[2:0], value[18:3], zero padding [23:19]
	input  logic [dcf_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata from bit 0: read_char[7:0], chars_written[10:8], unread_count[18:11],
	// free_count[26:19], zero padding [31:27]
	output logic [dcf_pkg::M_TDATA_W-1:0] m_tdata
);

	// Command and status bundles between the sequencer and the datapath.
	dcf_pkg::cmd_t  cmd;
	dcf_pkg::stat_t stat;

	dcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dcf_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ hw/rtl/dcf_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module dcf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/dcf_ctrl.sv @@
// Controller state machine sequencing decode, conversion, writes, reads and the result.
module dcf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  dcf_pkg::stat_t stat,
	output dcf_pkg::cmd_t  cmd
);

	dcf_pkg::state_t state_q;
	dcf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dcf_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = dcf_pkg::ST_DECODE;
			end
			dcf_pkg::ST_DECODE: begin
				if (stat.go_conv) begin
					state_d = dcf_pkg::ST_CONV;
				end else if (stat.go_write) begin
					state_d = dcf_pkg::ST_WRITE;
				end else if (stat.go_read) begin
					state_d = dcf_pkg::ST_READ;
				end else begin
					state_d = dcf_pkg::ST_RESP;
				end
			end
			dcf_pkg::ST_CONV: begin
				if (stat.conv_last) state_d = dcf_pkg::ST_WRITE;
			end
			dcf_pkg::ST_WRITE: begin
				if (stat.write_last) state_d = dcf_pkg::ST_RESP;
			end
			dcf_pkg::ST_READ:   state_d = dcf_pkg::ST_RDWAIT;
			dcf_pkg::ST_RDWAIT: state_d = dcf_pkg::ST_RESP;
			dcf_pkg::ST_RESP: begin
				if (stat.out_free) state_d = dcf_pkg::ST_IDLE;
			end
			default: state_d = dcf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			dcf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			dcf_pkg::ST_DECODE: cmd.decode       = 1'b1;
			dcf_pkg::ST_CONV:   cmd.conv_step    = 1'b1;
			dcf_pkg::ST_WRITE:  cmd.write_step   = 1'b1;
			dcf_pkg::ST_READ:   cmd.read_issue   = 1'b1;
			dcf_pkg::ST_RDWAIT: cmd.read_capture = 1'b1;
			dcf_pkg::ST_RESP:   cmd.out_load     = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

@@ hw/rtl/dcf_datapath.sv @@
// Datapath: pointers, decimal conversion, character generation, store and result register.
module dcf_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [dcf_pkg::S_TDATA_W-1:0]       s_tdata,
	input  dcf_pkg::cmd_t                       cmd,
	output dcf_pkg::stat_t                      stat,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dcf_pkg::M_TDATA_W-1:0]       m_tdata
);

	logic [dcf_pkg::FUNC_W-1:0]  func_q;
	logic [dcf_pkg::VALUE_W-1:0] value_q;
	dcf_pkg::ptr_t               rd_ptr_q;
	dcf_pkg::ptr_t               wr_ptr_q;
	logic [dcf_pkg::LEN_W-1:0]   len_q;
	logic [dcf_pkg::LEN_W-1:0]   idx_q;
	logic [dcf_pkg::LEN_W-1:0]   cnt_q;
	logic [dcf_pkg::VALUE_W-1:0] rem_q;
	logic [dcf_pkg::DIGIT_W-1:0] dig_q [dcf_pkg::NUM_DIGITS];
	logic [dcf_pkg::CHAR_W-1:0]  got_q;
	logic                        m_tvalid_q;
	logic [dcf_pkg::M_TDATA_W-1:0] m_tdata_q;

	dcf_pkg::ptr_t               unread;
	dcf_pkg::ptr_t               free_slots;
	logic [dcf_pkg::CNT_W-1:0]   unread_ext;
	logic [dcf_pkg::CNT_W-1:0]   free_ext;
	logic [dcf_pkg::LEN_W-1:0]   need;
	logic [dcf_pkg::LEN_W-1:0]   fmt_len;
	logic                        is_append;
	logic                        room_ok;
	logic [2*dcf_pkg::VALUE_W-1:0] product;
	logic [dcf_pkg::VALUE_W-1:0] quot;
	logic [dcf_pkg::VALUE_W-1:0] rem_diff;
	logic [dcf_pkg::LEN_W-1:0]   dig_sel;
	logic [dcf_pkg::DIGIT_W-1:0] dig_cur;
	logic [dcf_pkg::CHAR_W-1:0]  wchar;
	logic [dcf_pkg::CHAR_W-1:0]  rdata;

	// Occupancy; free slots are depth minus one minus unread, i.e. the complement.
	assign unread     = wr_ptr_q - rd_ptr_q;
	assign free_slots = ~unread;
	assign unread_ext = dcf_pkg::CNT_W'(unread);
	assign free_ext   = dcf_pkg::CNT_W'(free_slots);

	always_comb begin
		need      = '0;
		fmt_len   = '0;
		is_append = 1'b1;
		case (func_q)
			dcf_pkg::FUNC_CHAR: begin
				need    = dcf_pkg::NEED_CHAR;
				fmt_len = dcf_pkg::NEED_CHAR;
			end
			dcf_pkg::FUNC_DEC: begin
				need    = dcf_pkg::NEED_DEC;
				fmt_len = dcf_pkg::dec_len(value_q);
			end
			dcf_pkg::FUNC_HEX16: begin
				need    = dcf_pkg::NEED_HEX16;
				fmt_len = dcf_pkg::NEED_HEX16;
			end
			dcf_pkg::FUNC_HEX8: begin
				need    = dcf_pkg::NEED_HEX8;
				fmt_len = dcf_pkg::NEED_HEX8;
			end
			default: is_append = 1'b0;
		endcase
	end

	assign room_ok = free_slots >= dcf_pkg::PTR_W'(need);

	// One decimal digit per step: quotient by reciprocal multiply, remainder by shift-subtract.
	assign product  = rem_q * dcf_pkg::RECIP_TEN;
	assign quot     = dcf_pkg::VALUE_W'(product >> dcf_pkg::RECIP_SHIFT);
	assign rem_diff = rem_q - (quot << 3) - (quot << 1);

	// Digits go out most significant first.
	assign dig_sel = len_q - idx_q - 3'd1;

	always_comb begin
		case (dig_sel)
			3'd0:    dig_cur = dig_q[0];
			3'd1:    dig_cur = dig_q[1];
			3'd2:    dig_cur = dig_q[2];
			3'd3:    dig_cur = dig_q[3];
			3'd4:    dig_cur = dig_q[4];
			default: dig_cur = '0;
		endcase
	end

	always_comb begin
		wchar = dcf_pkg::CHAR_ZERO;
		case (func_q)
			dcf_pkg::FUNC_CHAR: wchar = value_q[7:0];
			dcf_pkg::FUNC_DEC:  wchar = dcf_pkg::CHAR_ZERO + {4'd0, dig_cur};
			dcf_pkg::FUNC_HEX16: begin
				case (idx_q)
					3'd0:    wchar = dcf_pkg::CHAR_ZERO;
					3'd1:    wchar = dcf_pkg::CHAR_X;
					3'd2:    wchar = dcf_pkg::hex_char(value_q[15:12]);
					3'd3:    wchar = dcf_pkg::hex_char(value_q[11:8]);
					3'd4:    wchar = dcf_pkg::hex_char(value_q[7:4]);
					default: wchar = dcf_pkg::hex_char(value_q[3:0]);
				endcase
			end
			dcf_pkg::FUNC_HEX8: begin
				case (idx_q)
					3'd0:    wchar = dcf_pkg::CHAR_ZERO;
					3'd1:    wchar = dcf_pkg::CHAR_X;
					3'd2:    wchar = dcf_pkg::hex_char(value_q[7:4]);
					default: wchar = dcf_pkg::hex_char(value_q[3:0]);
				endcase
			end
			default: wchar = dcf_pkg::CHAR_ZERO;
		endcase
	end

	dcf_ram #(
		.WIDTH(dcf_pkg::CHAR_W),
		.DEPTH(dcf_pkg::FIFO_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.write_step),
		.waddr (wr_ptr_q),
		.wdata (wchar),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	// Control state: pointers and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.write_step) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (cmd.read_capture) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= s_tdata[2:0];
			value_q <= s_tdata[18:3];
		end
		if (cmd.decode) begin
			len_q <= (is_append && room_ok) ? fmt_len : '0;
			rem_q <= value_q;
			cnt_q <= '0;
			idx_q <= '0;
			got_q <= '0;
		end
		if (cmd.conv_step) begin
			dig_q[cnt_q] <= rem_diff[3:0];
			rem_q        <= quot;
			cnt_q        <= cnt_q + 3'd1;
		end
		if (cmd.write_step) idx_q <= idx_q + 3'd1;
		if (cmd.read_capture) got_q <= rdata;
		if (cmd.out_load) begin
			m_tdata_q <= {5'd0, free_ext[7:0], unread_ext[7:0], len_q, got_q};
		end
	end

	assign stat.go_conv    = (func_q == dcf_pkg::FUNC_DEC) && room_ok;
	assign stat.go_write   = is_append && (func_q != dcf_pkg::FUNC_DEC) && room_ok;
	assign stat.go_read    = (func_q == dcf_pkg::FUNC_READ) && (unread != '0);
	assign stat.conv_last  = cnt_q == 3'd4;
	assign stat.write_last = idx_q == (len_q - 3'd1);
	assign stat.out_free   = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A write never lands on an unread character.
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_step |-> free_slots != '0)
		else $error("character write with the ring full");

	// A read is only issued with something held.
	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read_issue |-> unread != '0)
		else $error("read issued on an empty ring");

	// A new result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten");

	// Reported lengths never exceed six characters.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> len_q <= dcf_pkg::NEED_HEX16)
		else $error("character count out of range");

endmodule

@@ tb/testbench.sv @@
// Self-checking stream testbench for the debug character FIFO with number formatting.
module testbench;
	import dcf_pkg::*;

	// Command codes that the block leaves unused.
	localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_MID   = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 30;
	localparam int REPORT_CAP   = 200;
	localparam int RANDOM_ITEMS = 1880;

	typedef struct {
		logic [FUNC_W-1:0]  func;
		logic [VALUE_W-1:0] value;
	} dcf_cmd_s;

	typedef struct {
		logic [CHAR_W-1:0] rd_char;
		logic [LEN_W-1:0]  written;
		logic [7:0]        unread;
		logic [7:0]        free;
	} dcf_resp_s;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// Handshakes seen at the last rising edge, for the falling-edge drivers.
	logic s_taken = 1'b0;
	logic m_taken = 1'b0;

	dcf_cmd_s  pending_cmds[$];
	dcf_resp_s awaited_resp[$];
	dcf_cmd_s  drive_cmd;
	dcf_resp_s seen_resp;
	dcf_resp_s want_resp;

	// Shadow copy of the ring and its pointers.
	logic [CHAR_W-1:0] ring_model[FIFO_DEPTH];
	ptr_t              rd_ptr_m = '0;
	ptr_t              wr_ptr_m = '0;

	int err_count   = 0;
	int cycle_count = 0;
	int send_gap    = 0;
	int send_calm   = 0;
	int recv_stall  = 0;
	int recv_calm   = 0;
	int queued      = 0;

	debug_char_fifo_with_number_format dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		if (err_count < REPORT_CAP) begin
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		end
		err_count++;
	endtask

	function automatic int ring_unread();
		ptr_t diff;
		diff = wr_ptr_m - rd_ptr_m;
		return int'(diff);
	endfunction

	function automatic void ring_push(input logic [CHAR_W-1:0] c);
		ring_model[wr_ptr_m] = c;
		wr_ptr_m = wr_ptr_m + 1'b1;
	endfunction

	function automatic logic [CHAR_W-1:0] nibble_ascii(input logic [3:0] nib);
		logic [CHAR_W-1:0] wide;
		wide = {4'h0, nib};
		// Digits from '0', letters from 'A' in upper case.
		return (nib < 4'd10) ? (8'h30 + wide) : (8'h41 - 8'd10 + wide);
	endfunction

	// Applies one command to the shadow ring and returns the response it should give.
	function automatic dcf_resp_s fifo_response(input logic [FUNC_W-1:0] func,
			input logic [VALUE_W-1:0] value);
		dcf_resp_s r;
		int room;
		int v;
		int digit[NUM_DIGITS];
		bit lead;
		int unsigned left;
		r.rd_char = '0;
		r.written = '0;
		room = FIFO_DEPTH - 1 - ring_unread();
		case (func)
			FUNC_CHAR: begin
				if (room >= 1) begin
					ring_push(value[7:0]);
					r.written = 3'd1;
				end
			end
			FUNC_DEC: begin
				// Needs room for five digits even when fewer are written.
				if (room >= 5) begin
					v = int'(value);
					for (int i = 0; i < NUM_DIGITS; i++) begin
						digit[i] = v % 10;
						v = v / 10;
					end
					lead = 1'b1;
					for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
						if (!(lead && digit[i] == 0 && i != 0)) begin
							lead = 1'b0;
							ring_push(8'h30 + 8'(digit[i]));
							r.written = r.written + 1'b1;
						end
					end
				end
			end
			FUNC_HEX16: begin
				if (room >= 6) begin
					ring_push(8'h30);
					ring_push(8'h78);
					for (int s = 12; s >= 0; s -= 4) begin
						ring_push(nibble_ascii(value[s +: 4]));
					end
					r.written = 3'd6;
				end
			end
			FUNC_HEX8: begin
				// The high byte of the value plays no part.
				if (room >= 4) begin
					ring_push(8'h30);
					ring_push(8'h78);
					ring_push(nibble_ascii(value[7:4]));
					ring_push(nibble_ascii(value[3:0]));
					r.written = 3'd4;
				end
			end
			FUNC_READ: begin
				if (ring_unread() != 0) begin
					r.rd_char = ring_model[rd_ptr_m];
					rd_ptr_m = rd_ptr_m + 1'b1;
				end
			end
			default: begin
			end
		endcase
		left = FIFO_DEPTH - 1 - ring_unread();
		r.unread = 8'(ring_unread());
		r.free   = left[7:0];
		return r;
	endfunction

	// Wait draw for one transaction; now and then a stretch with no idling at all.
	function automatic int idle_draw(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 5);
	endfunction

	task automatic queue_cmd(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value);
		dcf_cmd_s c;
		c.func  = func;
		c.value = value;
		pending_cmds.push_back(c);
		queued++;
	endtask

	// Random command; append_pct sets how strongly the phase fills the ring.
	task automatic queue_random(input int append_pct);
		int roll;
		logic [FUNC_W-1:0]  f;
		logic [VALUE_W-1:0] v;
		// The run stops growing once the planned number of transactions is queued.
		if (queued >= RANDOM_ITEMS) begin
			return;
		end
		roll = $urandom_range(0, 99);
		v = VALUE_W'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			v = $urandom_range(0, 1) ? '1 : '0;
		end
		if (roll < 3) begin
			f = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
		end else if (roll < 3 + append_pct) begin
			f = FUNC_W'($urandom_range(FUNC_CHAR, FUNC_HEX8));
			// Spread decimal values over every digit count.
			if (f == FUNC_DEC) begin
				case ($urandom_range(1, 5))
					1: v = VALUE_W'($urandom_range(0, 9));
					2: v = VALUE_W'($urandom_range(10, 99));
					3: v = VALUE_W'($urandom_range(100, 999));
					4: v = VALUE_W'($urandom_range(1000, 9999));
					default: begin
					end
				endcase
			end
		end else begin
			f = FUNC_READ;
		end
		queue_cmd(f, v);
	endtask

	// Holds the sender back until the block has answered everything; the check runs
	// just after the falling edge so that the sender's updates are already visible.
	task automatic wait_quiet();
		@(negedge clk);
		#1;
		while (pending_cmds.size() != 0 || awaited_resp.size() != 0 || s_tvalid) begin
			@(negedge clk);
			#1;
		end
	endtask

	// Sender: a new transaction is presented at a falling edge once the last one was taken and any drawn gap is over.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_taken) begin
				send_gap = idle_draw(send_calm);
			end
			if (!s_tvalid || s_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					drive_cmd = pending_cmds.pop_front();
					s_tdata  <= {{(S_TDATA_W - FUNC_W - VALUE_W){1'b0}},
						drive_cmd.value, drive_cmd.func};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stalls for a drawn number of cycles after every result it takes.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (m_taken) begin
				recv_stall = idle_draw(recv_calm);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor: checks each result against the oldest prediction, then predicts new commands.
	always @(posedge clk) begin
		s_taken <= s_tvalid && s_tready;
		m_taken <= m_tvalid && m_tready;
		if (m_tvalid && m_tready) begin
			seen_resp.rd_char = m_tdata[7:0];
			seen_resp.written = m_tdata[10:8];
			seen_resp.unread  = m_tdata[18:11];
			seen_resp.free    = m_tdata[26:19];
			if (awaited_resp.size() == 0) begin
				flag_mismatch($sformatf("result with nothing outstanding, tdata %h", m_tdata));
			end else begin
				want_resp = awaited_resp.pop_front();
				if (seen_resp.rd_char !== want_resp.rd_char
						|| seen_resp.written !== want_resp.written
						|| seen_resp.unread !== want_resp.unread
						|| seen_resp.free !== want_resp.free) begin
					flag_mismatch($sformatf(
						"char %h/%h written %0d/%0d unread %0d/%0d free %0d/%0d (got/want)",
						seen_resp.rd_char, want_resp.rd_char,
						seen_resp.written, want_resp.written,
						seen_resp.unread, want_resp.unread,
						seen_resp.free, want_resp.free));
				end
			end
		end
		if (s_tvalid && s_tready) begin
			awaited_resp.push_back(fifo_response(s_tdata[FUNC_W-1:0],
				s_tdata[FUNC_W +: VALUE_W]));
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int phase;
		int phase_len;
		bit paused_mid;
		phase = 0;
		paused_mid = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: read of the empty ring, spare codes, each kind of append, then four reads.
		queue_cmd(FUNC_READ, 16'h1234);
		queue_cmd(FUNC_SPARE_FIRST, 16'hFFFF);
		queue_cmd(FUNC_SPARE_MID, 16'h0000);
		queue_cmd(FUNC_SPARE_LAST, 16'hFFFF);
		queue_cmd(FUNC_CHAR, 16'h0000);
		queue_cmd(FUNC_CHAR, 16'hFFFF);
		queue_cmd(FUNC_CHAR, 16'hA541);
		queue_cmd(FUNC_DEC, 16'd0);
		queue_cmd(FUNC_DEC, 16'd9);
		queue_cmd(FUNC_DEC, 16'd10);
		queue_cmd(FUNC_DEC, 16'd100);
		queue_cmd(FUNC_DEC, 16'd1000);
		queue_cmd(FUNC_DEC, 16'd10000);
		queue_cmd(FUNC_DEC, 16'd65535);
		// Zeros inside the number must stay.
		queue_cmd(FUNC_DEC, 16'd10005);
		queue_cmd(FUNC_HEX16, 16'h0000);
		queue_cmd(FUNC_HEX16, 16'hFFFF);
		queue_cmd(FUNC_HEX16, 16'h9A5F);
		queue_cmd(FUNC_HEX8, 16'h00FF);
		queue_cmd(FUNC_HEX8, 16'hFF00);
		queue_cmd(FUNC_HEX8, 16'h12AB);
		repeat (4) queue_cmd(FUNC_READ, 16'hFFFF);
		wait_quiet();

		// Random: fill phases push the ring to full, drain phases empty it, mixed ones wander.
		while (queued < RANDOM_ITEMS) begin
			case (phase % 3)
				0: begin
					phase_len = $urandom_range(90, 130);
					repeat (phase_len) queue_random(88);
				end
				1: begin
					phase_len = $urandom_range(260, 320);
					repeat (phase_len) queue_random(12);
				end
				default: begin
					phase_len = $urandom_range(60, 120);
					repeat (phase_len) queue_random(45);
				end
			endcase
			phase++;
			// Let the queue shrink to sixteen commands before topping it up, so the driver never starves long.
			while (pending_cmds.size() > 16) begin
				@(negedge clk);
			end
			if (!paused_mid && queued > RANDOM_ITEMS / 2) begin
				wait_quiet();
				paused_mid = 1'b1;
			end
		end
		wait_quiet();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (awaited_resp.size() != 0 || pending_cmds.size() != 0) begin
			flag_mismatch($sformatf("%0d results never arrived", awaited_resp.size()));
		end
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
